// File: rtl/core/rgb_to_hsl_converter_macros.svh
// ----------------------------------------------------------------------------
// RGB to HSL converter assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_MACROS_SVH

// same-cycle implication
`define RTH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rth_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter package
// Fixed widths and divider constants.
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam int CHAN_W  = 8;
  localparam int FIELD_W = 16;
  localparam int DIV_DW  = 12;  // widest divisor: 12 * 255
  localparam int DIV_SPS = 4;   // quotient bits per divider stage

endpackage

// File: rtl/core/rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Channel  Dir  Fields (tdata, low bit first)
// in_      in   red[7:0] green[15:8] blue[23:16]
// out_     out  hue[15:0] saturation[31:16] lightness[47:32]
// One item per cycle sustained while the output is not stalled. Registers:
// input, max/min, dividends, two pipelined dividers (4 quotient bits per
// stage), output; lightness is a constant multiply riding with the hue divider.
// Synchronous active-low reset clears all valid bits.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "rgb_to_hsl_converter_macros.svh"

module rgb_to_hsl_converter #(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red, green, blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // hue, saturation, lightness
);

  localparam int F   = FRACTION_BITS;
  localparam int NW  = F + 13;
  localparam int QW  = F + 1;
  localparam int DW  = rth_pkg::DIV_DW;
  localparam int CW  = rth_pkg::CHAN_W;
  localparam int FW  = rth_pkg::FIELD_W;
  // lightness = floor(sum * ceil(full * 2^P / 510) / 2^P + 1/2), exact for sum <= 510
  localparam int LIG_P = 18;
  localparam int LPW   = F + CW + 11;
  localparam longint unsigned LIG_DEN = 64'd510;
  localparam longint unsigned LIG_C =
    (((64'd1 << F) - 64'd1) * (64'd1 << LIG_P) + LIG_DEN - 64'd1) / LIG_DEN;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 0: input register
  logic          s0_vld_r;
  logic [CW-1:0] s0_r_r, s0_g_r, s0_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r_r <= in_tdata[7:0];
      s0_g_r <= in_tdata[15:8];
      s0_b_r <= in_tdata[23:16];
    end
  end

  // stage 1: max/min, hue numerator
  logic [CW-1:0] mx, mn, dl;
  logic [CW:0]   sm, dn;
  logic [10:0]   six, hn;

  always_comb begin
    logic [11:0] t;
    mx = s0_r_r;
    mn = s0_r_r;
    if (s0_g_r > mx) mx = s0_g_r;
    if (s0_b_r > mx) mx = s0_b_r;
    if (s0_g_r < mn) mn = s0_g_r;
    if (s0_b_r < mn) mn = s0_b_r;
    dl  = mx - mn;
    sm  = {1'b0, mx} + {1'b0, mn};
    dn  = (sm < 9'd255) ? sm : (9'd510 - sm);
    six = 11'(dl) * 11'd6;
    if (s0_r_r == mx) begin
      t = (12'(six) + 12'(s0_g_r)) - 12'(s0_b_r);
    end else if (s0_g_r == mx) begin
      t = (12'({dl, 1'b0}) + 12'(s0_b_r)) - 12'(s0_r_r);
    end else begin
      t = (12'({dl, 2'b0}) + 12'(s0_r_r)) - 12'(s0_g_r);
    end
    if (t >= 12'(six)) t = t - 12'(six);
    hn = t[10:0];
  end

  logic          s1_vld_r, s1_grey_r;
  logic [CW-1:0] s1_del_r;
  logic [CW:0]   s1_sum_r, s1_den_r;
  logic [10:0]   s1_six_r, s1_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_grey_r <= (dl == '0);
      s1_del_r  <= dl;
      s1_sum_r  <= sm;
      s1_den_r  <= dn;
      s1_six_r  <= six;
      s1_num_r  <= hn;
    end
  end

  // stage 2: rounded dividends (2n + d) over 2d, lightness product
  logic          s2_vld_r, s2_grey_r;
  logic [NW-1:0] s2_hn_r, s2_sn_r;
  logic [DW-1:0] s2_hd_r, s2_sd_r;
  logic [F-1:0]  s2_lig_r;
  logic [LPW-1:0] lig_prod;

  assign lig_prod = LPW'(s1_sum_r) * LPW'(LIG_C) + (LPW'(1) << (LIG_P - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_grey_r <= s1_grey_r;
      s2_hn_r   <= NW'({s1_num_r, {(F + 1){1'b0}}}) + NW'(s1_six_r);
      s2_sn_r   <= NW'({s1_del_r, {(F + 1){1'b0}}}) - NW'({s1_del_r, 1'b0})
                   + NW'(s1_den_r);
      s2_lig_r  <= lig_prod[LIG_P +: F];
      s2_hd_r   <= DW'({s1_six_r, 1'b0});
      s2_sd_r   <= DW'({s1_den_r, 1'b0});
    end
  end

  // dividers; grey flag and lightness travel as the hue divider's tag
  logic          dv_vld, dv_grey;
  logic [F:0]    dv_tag;
  logic [QW-1:0] hq, sq;

  assign dv_grey = dv_tag[0];

  rth_div #(.NW(NW), .DW(DW), .QW(QW), .TW(F + 1)) u_hue_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s2_vld_r),
    .in_tag  ({s2_lig_r, s2_grey_r}),
    .num     (s2_hn_r),
    .den     (s2_hd_r),
    .out_vld (dv_vld),
    .out_tag (dv_tag),
    .quo     (hq)
  );

  rth_div #(.NW(NW), .DW(DW), .QW(QW), .TW(1)) u_sat_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s2_vld_r),
    .in_tag  (1'b0),
    .num     (s2_sn_r),
    .den     (s2_sd_r),
    .out_vld (),
    .out_tag (),
    .quo     (sq)
  );

  // output stage: hue wrap, grey override
  logic [QW-1:0]    hw;
  logic [QW+FW-1:0] hx, sx;
  logic [F+FW-1:0]  lx;

  assign hw = (hq == (QW'(1) << F)) ? '0 : hq;
  assign hx = {{FW{1'b0}}, hw};
  assign sx = {{FW{1'b0}}, sq};
  assign lx = {{FW{1'b0}}, dv_tag[F:1]};

  logic          out_vld_r, out_grey_r;
  logic [FW-1:0] hue_r, sat_r, lig_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_grey_r <= dv_grey;
      hue_r      <= dv_grey ? '0 : hx[FW-1:0];
      sat_r      <= dv_grey ? '0 : sx[FW-1:0];
      lig_r      <= lx[FW-1:0];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {lig_r, sat_r, hue_r};

  `RTH_ASSERT_NOW(a_grey_zero, out_vld_r && out_grey_r, hue_r == '0 && sat_r == '0, "grey item has nonzero hue or saturation")
  `RTH_ASSERT_NOW(a_ready_rule, 1'b1, in_tready == (out_tready || !out_vld_r), "input ready does not follow output space")
  `RTH_ASSERT_NEXT(a_stall_hold, out_vld_r && !out_tready, out_vld_r && $stable(out_tdata) && $stable(s2_vld_r), "pipeline moved during stall")

endmodule

// File: rtl/core/rth_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned NW-bit by DW-bit division, DIV_SPS quotient bits per stage,
// with a tag and a valid bit carried alongside.
// ----------------------------------------------------------------------------
module rth_div #(
  parameter int NW = 29,
  parameter int DW = 12,
  parameter int QW = 17,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [TW-1:0] in_tag,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          out_vld,
  output logic [TW-1:0] out_tag,
  output logic [QW-1:0] quo
);

  localparam int SPS = rth_pkg::DIV_SPS;
  localparam int NS  = (NW + SPS - 1) / SPS;

  logic          vld_r [NS];
  logic [TW-1:0] tag_r [NS];
  logic [DW-1:0] rem_r [NS];
  logic [NW-1:0] dvd_r [NS];
  logic [DW-1:0] den_r [NS];
  logic [QW-1:0] quo_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic          vld_src;
    logic [TW-1:0] tag_src;
    logic [DW-1:0] rem_src;
    logic [NW-1:0] dvd_src;
    logic [DW-1:0] den_src;
    logic [QW-1:0] quo_src;
    logic [DW-1:0] rem_nxt;
    logic [NW-1:0] dvd_nxt;
    logic [QW-1:0] quo_nxt;

    if (s == 0) begin : g_head
      assign vld_src = in_vld;
      assign tag_src = in_tag;
      assign rem_src = '0;
      assign dvd_src = num;
      assign den_src = den;
      assign quo_src = '0;
    end else begin : g_body
      assign vld_src = vld_r[s-1];
      assign tag_src = tag_r[s-1];
      assign rem_src = rem_r[s-1];
      assign dvd_src = dvd_r[s-1];
      assign den_src = den_r[s-1];
      assign quo_src = quo_r[s-1];
    end

    always_comb begin
      logic [DW:0]   rw;
      logic [NW-1:0] dw;
      logic [QW-1:0] qw;
      rw = {1'b0, rem_src};
      dw = dvd_src;
      qw = quo_src;
      for (int j = 0; j < SPS; j++) begin
        if (s * SPS + j < NW) begin
          rw = {rw[DW-1:0], dw[NW-1]};
          dw = {dw[NW-2:0], 1'b0};
          qw = {qw[QW-2:0], 1'b0};
          if (rw >= {1'b0, den_src}) begin
            rw    = rw - {1'b0, den_src};
            qw[0] = 1'b1;
          end
        end
      end
      rem_nxt = rw[DW-1:0];
      dvd_nxt = dw;
      quo_nxt = qw;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[s] <= tag_src;
        rem_r[s] <= rem_nxt;
        dvd_r[s] <= dvd_nxt;
        den_r[s] <= den_src;
        quo_r[s] <= quo_nxt;
      end
    end
  end

  assign out_vld = vld_r[NS-1];
  assign out_tag = tag_r[NS-1];
  assign quo     = quo_r[NS-1];

endmodule

// File: bench/tb_rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter testbench
// Streams directed and random pixels through the converter under random
// source and sink stalls, predicts hue, saturation and lightness per pixel
// with exact integer arithmetic and checks every output item in order.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsl_converter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FBITS     = 16;
  localparam int WDOG_MAX  = 2000;
  localparam int DRAIN_CYC = 40;

  typedef struct packed {
    logic [15:0] lig;
    logic [15:0] sat;
    logic [15:0] hue;
  } hsl_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  logic [23:0] pixel_q[$];
  hsl_t        hsl_q[$];
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          n_err = 0;
  int          wdog = 0;
  bit          timed_out = 1'b0;
  bit          in_taken = 1'b0;

  rgb_to_hsl_converter #(.FRACTION_BITS(FBITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
    return (n * 2 + d) / (d * 2);
  endfunction

  function automatic hsl_t rgb_to_hsl(logic [23:0] px);
    longint unsigned r, g, b, mx, mn, dl, sm, six, num, den, h, s, l;
    longint unsigned turn, full;
    hsl_t res;
    r = 64'(px[7:0]); g = 64'(px[15:8]); b = 64'(px[23:16]);
    turn = 64'd1 << FBITS;
    full = turn - 1;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    sm = mx + mn;
    l = rdiv(sm * full, 510);
    h = 0; s = 0;
    if (dl != 0) begin
      six = 6 * dl;
      den = (sm < 255) ? sm : 510 - sm;
      s = rdiv(dl * full, den);
      if (r == mx) num = six + g - b;
      else if (g == mx) num = 2 * dl + b - r;
      else num = 4 * dl + r - g;
      if (num >= six) num -= six;
      h = rdiv(num * turn, six);
      if (h >= turn) h -= turn;
    end
    res.hue = h[15:0];
    res.sat = s[15:0];
    res.lig = l[15:0];
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_taken) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pixel_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    hsl_t got, want;
    if (rst_n) begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) hsl_q.push_back(rgb_to_hsl(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (hsl_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected item %h", got);
        end else begin
          want = hsl_q.pop_front();
          if (got !== want) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch: exp hue %h sat %h lig %h, got hue %h sat %h lig %h",
                       want.hue, want.sat, want.lig, got.hue, got.sat, got.lig);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wdog <= 0;
      else if (wdog + 1 >= WDOG_MAX) timed_out = 1'b1;
      else wdog <= wdog + 1;
    end
  end

  always @(posedge clk) begin
    if (timed_out) begin
      $display("tb_rgb_to_hsl_converter NOT OK");
      $finish;
    end
  end

  task automatic push_rgb(int r, int g, int b);
    pixel_q.push_back({b[7:0], g[7:0], r[7:0]});
  endtask

  task automatic drain();
    while (pixel_q.size() > 0 || in_tvalid || hsl_q.size() > 0) @(posedge clk);
  endtask

  task automatic push_random(int n);
    int k, hi, lo;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      if (k == 0) begin
        k = $urandom_range(255);
        push_rgb(k, k, k);
      end else if (k == 1) begin
        hi = $urandom_range(255);
        lo = $urandom_range(hi);
        case ($urandom_range(5))
          0: push_rgb(hi, hi, lo);
          1: push_rgb(hi, lo, hi);
          2: push_rgb(lo, hi, hi);
          3: push_rgb(hi, lo, lo);
          4: push_rgb(lo, hi, lo);
          default: push_rgb(lo, lo, hi);
        endcase
      end else begin
        pixel_q.push_back(24'($urandom()));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, greys, each max channel, ties, hue wrap
    push_rgb(0, 0, 0);       push_rgb(255, 255, 255); push_rgb(128, 128, 128);
    push_rgb(255, 0, 0);     push_rgb(0, 255, 0);     push_rgb(0, 0, 255);
    push_rgb(255, 255, 0);   push_rgb(0, 255, 255);   push_rgb(255, 0, 255);
    push_rgb(255, 0, 1);     push_rgb(255, 1, 0);     push_rgb(254, 0, 1);
    push_rgb(1, 0, 0);       push_rgb(255, 254, 254); push_rgb(127, 128, 0);
    push_rgb(128, 127, 0);   push_rgb(1, 2, 3);       push_rgb(200, 100, 50);
    push_rgb(0, 1, 255);     push_rgb(170, 85, 255);  push_rgb(85, 170, 0);
    drain();
    src_idle_pct = 34; snk_idle_pct = 65;
    push_random(450);
    drain();
    src_idle_pct = 65; snk_idle_pct = 34;
    push_random(450);
    drain();
    src_idle_pct = 0; snk_idle_pct = 0;
    push_random(480);
    drain();
    repeat (DRAIN_CYC) @(posedge clk);
    if (n_err == 0) $display("tb_rgb_to_hsl_converter OK");
    else $display("tb_rgb_to_hsl_converter NOT OK");
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/rth_pkg.sv
rtl/core/rth_div.sv
rtl/core/rgb_to_hsl_converter.sv
bench/tb_rgb_to_hsl_converter.sv
